@@ hdl/mpdc_pkg.sv @@
// ----------------------------------------------------------------------------
// mpdc_pkg: shared definitions for the microphone pair delay correlator
// Store geometry, lag range, sample scaling and the controller-to-datapath
// command bundle.
// ----------------------------------------------------------------------------
package mpdc_pkg;

    // Store geometry (depth must be a power of two, 32 .. 8192)
    localparam int DEPTH     = 2048;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int FILL_W    = ADDR_W + 1;

    // Lag search runs from -LAG_RANGE to LAG_RANGE-1 (LAG_RANGE 1 .. 16)
    localparam int LAG_RANGE = 10;
    localparam int LAG_W     = 5;
    localparam logic signed [LAG_W-1:0] LAG_FIRST = LAG_W'(-LAG_RANGE);
    localparam logic signed [LAG_W-1:0] LAG_LAST  = LAG_W'(LAG_RANGE - 1);

    // Command codes on the command port
    localparam logic CMD_CAPTURE = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // Samples: 12-bit raw, divided by 20 to 0..204
    localparam int RAW_W       = 12;
    localparam int SAMPLE_W    = 8;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    // ceil(2^16 / 20); exact for every 12-bit input
    localparam logic [RECIP_W-1:0] RECIP_20 = RECIP_W'(3277);

    // Products of two scaled samples fit 16 bits (204*204 = 41616)
    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int SUM_W  = PROD_W + ADDR_W;

    typedef struct packed {
        logic                     capture;  // write one sample set
        logic                     begin_op; // start of a compute: reset search
        logic                     issue;    // read one product term
        logic                     eval;     // close out the current lag
        logic [ADDR_W-1:0]        t;        // index into the first store
        logic signed [LAG_W-1:0]  lag;      // lag under test
    } dp_cmd_t;

    // raw / 20 by reciprocal multiply
    function automatic logic [SAMPLE_W-1:0] scale_sample(input logic [RAW_W-1:0] raw);
        logic [RAW_W+RECIP_W-1:0] prod;
        prod = raw * RECIP_20;
        return prod[RECIP_SHIFT +: SAMPLE_W];
    endfunction

endpackage

@@ hdl/mpdc_ram.sv @@
// ----------------------------------------------------------------------------
// mpdc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mpdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/mpdc_datapath.sv @@
// ----------------------------------------------------------------------------
// mpdc_datapath: sample stores, product pipeline and best-lag search
// Four capture stores, write position and fill tracking, two multiply and
// accumulate lanes (pair x, pair y) and the running best-lag registers.
// ----------------------------------------------------------------------------
module mpdc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mpdc_pkg::dp_cmd_t                   cmd,
    input  logic [mpdc_pkg::RAW_W-1:0]          raw_mic_one,
    input  logic [mpdc_pkg::RAW_W-1:0]          raw_mic_two,
    input  logic [mpdc_pkg::RAW_W-1:0]          raw_mic_three,
    input  logic [mpdc_pkg::RAW_W-1:0]          raw_mic_four,
    output logic signed [mpdc_pkg::LAG_W-1:0]   delay_x,
    output logic signed [mpdc_pkg::LAG_W-1:0]   delay_y
);

    import mpdc_pkg::*;

    logic [ADDR_W-1:0]   pos_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic                full_reg;
    logic                we;
    logic [ADDR_W-1:0]   j_addr;
    logic                va, vb;

    logic [SAMPLE_W-1:0] rd_one, rd_two, rd_three, rd_four;
    logic                s1_valid_reg, s1_va_reg, s1_vb_reg;
    logic [SAMPLE_W-1:0] a_x, b_x, a_y, b_y;

    logic                s2_valid_reg;
    logic [PROD_W-1:0]   prod_x_reg, prod_y_reg;

    logic [SUM_W-1:0]    acc_x_reg, acc_y_reg;
    logic [SUM_W-1:0]    best_x_reg, best_y_reg;
    logic signed [LAG_W-1:0] lag_x_reg, lag_y_reg;

    assign we     = cmd.capture && !full_reg;
    // circular index: t + lag mod DEPTH
    assign j_addr = cmd.t + {{(ADDR_W-LAG_W){cmd.lag[LAG_W-1]}}, cmd.lag};
    // entries at or beyond the fill mark were never written and read as zero
    assign va     = {1'b0, cmd.t}  < fill_reg;
    assign vb     = {1'b0, j_addr} < fill_reg;

    mpdc_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_store_one (
        .clk(clk), .we(we), .waddr(pos_reg), .wdata(scale_sample(raw_mic_one)),
        .raddr(cmd.t), .rdata(rd_one)
    );
    mpdc_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_store_two (
        .clk(clk), .we(we), .waddr(pos_reg), .wdata(scale_sample(raw_mic_two)),
        .raddr(j_addr), .rdata(rd_two)
    );
    mpdc_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_store_three (
        .clk(clk), .we(we), .waddr(pos_reg), .wdata(scale_sample(raw_mic_three)),
        .raddr(cmd.t), .rdata(rd_three)
    );
    mpdc_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_store_four (
        .clk(clk), .we(we), .waddr(pos_reg), .wdata(scale_sample(raw_mic_four)),
        .raddr(j_addr), .rdata(rd_four)
    );

    // write position, fill mark and full flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
            full_reg <= 1'b0;
        end
        else if (cmd.begin_op)
        begin
            full_reg <= 1'b0;
        end
        else if (we)
        begin
            pos_reg <= pos_reg + 1'b1;
            if (pos_reg == ADDR_W'(DEPTH - 1))
            begin
                full_reg <= 1'b1;
            end
            if (fill_reg != FILL_W'(DEPTH))
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    assign a_x = s1_va_reg ? rd_one   : '0;
    assign b_x = s1_vb_reg ? rd_two   : '0;
    assign a_y = s1_va_reg ? rd_three : '0;
    assign b_y = s1_vb_reg ? rd_four  : '0;

    // read stage -> product stage -> accumulate, then per-lag compare
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_va_reg    <= 1'b0;
            s1_vb_reg    <= 1'b0;
            s2_valid_reg <= 1'b0;
            prod_x_reg   <= '0;
            prod_y_reg   <= '0;
            acc_x_reg    <= '0;
            acc_y_reg    <= '0;
            best_x_reg   <= '0;
            best_y_reg   <= '0;
            lag_x_reg    <= '0;
            lag_y_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s1_va_reg    <= va;
            s1_vb_reg    <= vb;
            s2_valid_reg <= s1_valid_reg;
            prod_x_reg   <= a_x * b_x;
            prod_y_reg   <= a_y * b_y;

            if (cmd.begin_op)
            begin
                acc_x_reg  <= '0;
                acc_y_reg  <= '0;
                best_x_reg <= '0;
                best_y_reg <= '0;
                lag_x_reg  <= '0;
                lag_y_reg  <= '0;
            end
            else if (cmd.eval)
            begin
                // strict compare: earliest lag wins a tie
                if (acc_x_reg > best_x_reg)
                begin
                    best_x_reg <= acc_x_reg;
                    lag_x_reg  <= cmd.lag;
                end
                if (acc_y_reg > best_y_reg)
                begin
                    best_y_reg <= acc_y_reg;
                    lag_y_reg  <= cmd.lag;
                end
                acc_x_reg <= '0;
                acc_y_reg <= '0;
            end
            else if (s2_valid_reg)
            begin
                acc_x_reg <= acc_x_reg + SUM_W'(prod_x_reg);
                acc_y_reg <= acc_y_reg + SUM_W'(prod_y_reg);
            end
        end
    end

    assign delay_x = lag_x_reg;
    assign delay_y = lag_y_reg;

endmodule

@@ hdl/mpdc_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpdc_ctrl: command handshake and correlation sequencer
// Takes capture and compute commands, sweeps lag and index for a compute,
// and flags the result cycle.
// ----------------------------------------------------------------------------
module mpdc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              command,
    output logic              busy,
    output logic              done,
    output mpdc_pkg::dp_cmd_t cmd
);

    import mpdc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_FLUSH = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // last flush step while the product pipeline behind the read drains
    localparam logic FLUSH_LAST = 1'b1;

    logic [2:0]              state_reg, state_next;
    logic [ADDR_W-1:0]       t_reg, t_next;
    logic signed [LAG_W-1:0] lag_reg, lag_next;
    logic                    flush_reg, flush_next;
    logic                    accept;

    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        lag_next   = lag_reg;
        flush_next = flush_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && command == CMD_COMPUTE)
                begin
                    state_next = S_RUN;
                    t_next     = '0;
                    lag_next   = LAG_FIRST;
                end
            end
            S_RUN:
            begin
                t_next = t_reg + 1'b1;
                if (t_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_FLUSH;
                    flush_next = 1'b0;
                end
            end
            S_FLUSH:
            begin
                flush_next = 1'b1;
                if (flush_reg == FLUSH_LAST)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (lag_reg == LAG_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    lag_next   = lag_reg + 1'b1;
                    state_next = S_RUN;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            t_reg     <= '0;
            lag_reg   <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            t_reg     <= t_next;
            lag_reg   <= lag_next;
            flush_reg <= flush_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    always_comb
    begin
        cmd.capture  = accept && command == CMD_CAPTURE;
        cmd.begin_op = accept && command == CMD_COMPUTE;
        cmd.issue    = (state_reg == S_RUN);
        cmd.eval     = (state_reg == S_EVAL);
        cmd.t        = t_reg;
        cmd.lag      = lag_reg;
    end

endmodule

@@ hdl/mic_pair_delay_correlator.sv @@
// ----------------------------------------------------------------------------
// mic_pair_delay_correlator: two-pair microphone delay estimator
// Captures four microphone streams into circular stores and finds, for each
// microphone pair, the lag with the strongest circular cross-correlation.
// ----------------------------------------------------------------------------
//
// Usage: a transfer happens on a rising edge with start high and busy low.
// A capture (command 0) leaves busy low, so between computes the sampling
// side can issue one capture every clock. Each raw sample is divided by 20
// and stored at the shared write position; after DEPTH captures the stores
// are full and further captures are dropped until the next compute.
// A compute (command 1) clears the full flag and holds busy high through
// the whole run, up to and including the done cycle: each lag reads every
// store entry once through the single read port of each store, then drains
// the multiply-accumulate pipeline and compares. The result shows on
// delay_x / delay_y with done high for exactly one cycle; there is no
// backpressure, so the receiver must take it then. Captures never issue a
// result.
// Stores need no clearing pass after reset: a fill mark makes entries that
// were never written read as zero. DEPTH must be a power of two.
//
module mic_pair_delay_correlator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              command,
    input  logic [mpdc_pkg::RAW_W-1:0]        raw_mic_one,
    input  logic [mpdc_pkg::RAW_W-1:0]        raw_mic_two,
    input  logic [mpdc_pkg::RAW_W-1:0]        raw_mic_three,
    input  logic [mpdc_pkg::RAW_W-1:0]        raw_mic_four,
    output logic                              done,
    output logic signed [mpdc_pkg::LAG_W-1:0] delay_x,
    output logic signed [mpdc_pkg::LAG_W-1:0] delay_y
);

    import mpdc_pkg::*;

    // command bundle from sequencer to datapath
    dp_cmd_t cmd;

    // Controller: handshake, lag/index sweep, pipeline drain, result strobe
    mpdc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .done    (done),
        .cmd     (cmd)
    );

    // Datapath: four stores, two MAC lanes, best-lag tracking
    mpdc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .raw_mic_one   (raw_mic_one),
        .raw_mic_two   (raw_mic_two),
        .raw_mic_three (raw_mic_three),
        .raw_mic_four  (raw_mic_four),
        .delay_x       (delay_x),
        .delay_y       (delay_y)
    );

endmodule

@@ tb/tb_mic_pair_delay_correlator.sv @@
// ----------------------------------------------------------------------------
// tb_mic_pair_delay_correlator: self-checking bench for the pair delay block
// A driver feeds capture and compute transfers from a queue that the stimulus
// block fills. A monitor keeps its own copy of the four sample stores, works
// out both pair lags for each compute it sees go in, and checks every done
// strobe against the oldest pending lag pair.
// ----------------------------------------------------------------------------
module tb_mic_pair_delay_correlator;

    localparam int DEPTH      = mpdc_pkg::DEPTH;
    localparam int LAG_RANGE  = mpdc_pkg::LAG_RANGE;
    localparam int LAG_W      = mpdc_pkg::LAG_W;
    localparam int RAW_W      = mpdc_pkg::RAW_W;
    localparam int SAMPLE_DIV = 20;

    localparam bit CMD_CAPTURE = mpdc_pkg::CMD_CAPTURE;
    localparam bit CMD_COMPUTE = mpdc_pkg::CMD_COMPUTE;

    // busy length of one compute, used to size the watchdog
    localparam int COMPUTE_CYCLES = 2 * LAG_RANGE * (DEPTH + 3) + 1;

    // one pending transfer
    typedef struct {
        bit               command;
        logic [RAW_W-1:0] mic1;
        logic [RAW_W-1:0] mic2;
        logic [RAW_W-1:0] mic3;
        logic [RAW_W-1:0] mic4;
        bit               steady;      // never idle before this one
        bit               drain_first; // hold until no result is pending
    } mic_xfer_t;

    typedef struct packed {
        logic signed [LAG_W-1:0] dx;
        logic signed [LAG_W-1:0] dy;
    } lag_pair_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    command;
    logic [RAW_W-1:0]        raw_mic_one;
    logic [RAW_W-1:0]        raw_mic_two;
    logic [RAW_W-1:0]        raw_mic_three;
    logic [RAW_W-1:0]        raw_mic_four;
    logic                    done;
    logic signed [LAG_W-1:0] delay_x;
    logic signed [LAG_W-1:0] delay_y;

    mic_pair_delay_correlator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .raw_mic_one   (raw_mic_one),
        .raw_mic_two   (raw_mic_two),
        .raw_mic_three (raw_mic_three),
        .raw_mic_four  (raw_mic_four),
        .done          (done),
        .delay_x       (delay_x),
        .delay_y       (delay_y)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    mic_xfer_t  pend_q[$];        // transfers not yet driven
    lag_pair_t  lag_expect_q[$];  // lag pairs owed by the block

    // predictor copy of the stores: 0..3 = microphones one..four
    bit [7:0]   mic_mem [4][DEPTH];
    int         wr_pos;
    bit         mem_full;

    // stimulus-side mirror of the write position, used to plan a wrap
    int         gen_pos;
    bit         gen_full;

    bit         xfer_seen;        // transfer at the last rising edge
    int         cycle_count;
    int         cycle_limit;
    int         n_errors;
    int         n_stored;
    int         n_dropped;
    int         n_results;

    task automatic flag_mismatch(input string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        n_errors++;
    endtask

    function automatic bit [7:0] scaled(input logic [RAW_W-1:0] raw);
        return 8'(int'(raw) / SAMPLE_DIV);
    endfunction

    // circular cross-correlation over the full store; first strictly larger
    // sum wins, so ties keep the most negative lag and all-zero gives 0
    function automatic logic signed [LAG_W-1:0] find_best_lag(input int sa, input int sb);
        longint best_sum;
        longint sum;
        int     best_lag;
        int     lag;
        int     t;
        best_sum = 0;
        best_lag = 0;
        for (lag = -LAG_RANGE; lag < LAG_RANGE; lag++)
        begin
            sum = 0;
            for (t = 0; t < DEPTH; t++)
                sum += longint'(mic_mem[sa][t]) * longint'(mic_mem[sb][(t + DEPTH + lag) % DEPTH]);
            if (sum > best_sum)
            begin
                best_sum = sum;
                best_lag = lag;
            end
        end
        return LAG_W'(best_lag);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // about a quarter of draws land on the divide boundaries and the rails
    function automatic logic [RAW_W-1:0] pick_raw();
        logic [RAW_W-1:0] edge_vals [7] = '{12'd0, 12'd19, 12'd20, 12'd2047,
                                             12'd2048, 12'd4094, 12'd4095};
        if ($urandom_range(99) < 25)
            return edge_vals[$urandom_range(6)];
        return RAW_W'($urandom_range(4095));
    endfunction

    function automatic int pick_lag();
        return int'($urandom_range(2 * LAG_RANGE - 1)) - LAG_RANGE;
    endfunction

    task automatic queue_capture(input logic [RAW_W-1:0] a, input logic [RAW_W-1:0] b,
                                 input logic [RAW_W-1:0] c, input logic [RAW_W-1:0] d,
                                 input bit steady);
        mic_xfer_t x;
        x.command     = CMD_CAPTURE;
        x.mic1        = a;
        x.mic2        = b;
        x.mic3        = c;
        x.mic4        = d;
        x.steady      = steady;
        x.drain_first = 1'b0;
        pend_q.push_back(x);
        if (!gen_full)
        begin
            gen_pos++;
            if (gen_pos == DEPTH)
            begin
                gen_pos  = 0;
                gen_full = 1'b1;
            end
        end
    endtask

    // raw fields carry junk: the block must ignore them on a compute
    task automatic queue_compute(input bit drain);
        mic_xfer_t x;
        x.command     = CMD_COMPUTE;
        x.mic1        = pick_raw();
        x.mic2        = pick_raw();
        x.mic3        = pick_raw();
        x.mic4        = pick_raw();
        x.steady      = 1'b0;
        x.drain_first = drain;
        pend_q.push_back(x);
        gen_full = 1'b0;
    endtask

    // Second mic of each pair hears the first one delayed by dx / dy samples
    // (negative = leads), with a little independent noise mixed in.
    task automatic queue_delayed_burst(input int len, input int dx, input int dy,
                                       input bit steady);
        logic [RAW_W-1:0] sx[$];
        logic [RAW_W-1:0] sy[$];
        logic [RAW_W-1:0] m2;
        logic [RAW_W-1:0] m4;
        int               n;
        for (n = 0; n < len + 2 * LAG_RANGE; n++)
        begin
            sx.push_back(pick_raw());
            sy.push_back(pick_raw());
        end
        for (n = 0; n < len; n++)
        begin
            m2 = sx[n + LAG_RANGE - dx];
            m4 = sy[n + LAG_RANGE - dy];
            if ($urandom_range(99) < 10)
                m2 = pick_raw();
            if ($urandom_range(99) < 10)
                m4 = pick_raw();
            queue_capture(sx[n + LAG_RANGE], m2, sy[n + LAG_RANGE], m4, steady);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: inputs move on the falling edge. A transfer that has not gone
    // in yet stays on the ports; otherwise the next one is popped unless the
    // sender idles this cycle or waits for the block to drain.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        mic_xfer_t nxt;
        bit        go;
        if (!rst_n)
        begin
            start         <= 1'b0;
            command       <= CMD_CAPTURE;
            raw_mic_one   <= '0;
            raw_mic_two   <= '0;
            raw_mic_three <= '0;
            raw_mic_four  <= '0;
        end
        else if (!start || xfer_seen)
        begin
            go = 1'b0;
            if (pend_q.size() > 0)
            begin
                nxt = pend_q[0];
                if (nxt.drain_first && lag_expect_q.size() != 0)
                    go = 1'b0;
                else if (!nxt.steady && $urandom_range(99) < 20)
                    go = 1'b0;
                else
                    go = 1'b1;
            end
            if (go)
            begin
                void'(pend_q.pop_front());
                command       <= nxt.command;
                raw_mic_one   <= nxt.mic1;
                raw_mic_two   <= nxt.mic2;
                raw_mic_three <= nxt.mic3;
                raw_mic_four  <= nxt.mic4;
            end
            start <= go;
        end
    end

    always @(posedge clk)
        cycle_count++;

    // ------------------------------------------------------------------------
    // Monitor: on each rising edge, check a done strobe first (it belongs to
    // an earlier compute), then apply a transfer that goes in at this edge to
    // the predictor stores.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        lag_pair_t got;
        lag_pair_t want;
        if (rst_n)
        begin
            xfer_seen <= start && !busy;

            if (done)
            begin
                got.dx = delay_x;
                got.dy = delay_y;
                n_results++;
                if (lag_expect_q.size() == 0)
                    flag_mismatch($sformatf("done with no compute pending (x %0d, y %0d)",
                                            got.dx, got.dy));
                else
                begin
                    want = lag_expect_q.pop_front();
                    if (got.dx !== want.dx)
                        flag_mismatch($sformatf("delay_x got %0d want %0d", got.dx, want.dx));
                    if (got.dy !== want.dy)
                        flag_mismatch($sformatf("delay_y got %0d want %0d", got.dy, want.dy));
                end
            end

            if (start && !busy)
            begin
                if (command == CMD_CAPTURE)
                begin
                    // stores hold still once full until the next compute
                    if (mem_full)
                        n_dropped++;
                    else
                    begin
                        mic_mem[0][wr_pos] = scaled(raw_mic_one);
                        mic_mem[1][wr_pos] = scaled(raw_mic_two);
                        mic_mem[2][wr_pos] = scaled(raw_mic_three);
                        mic_mem[3][wr_pos] = scaled(raw_mic_four);
                        n_stored++;
                        wr_pos++;
                        if (wr_pos == DEPTH)
                        begin
                            wr_pos   = 0;
                            mem_full = 1'b1;
                        end
                    end
                end
                else
                begin
                    // compute clears full; write position stays where it is
                    mem_full = 1'b0;
                    want.dx  = find_best_lag(0, 1);
                    want.dy  = find_best_lag(2, 3);
                    lag_expect_q.push_back(want);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int  ph;
        int  n;
        int  n_items;
        int  n_compute;
        bit  timed_out;

        rst_n         = 1'b0;
        timed_out     = 1'b0;

        // --- directed ---
        // compute on empty stores: no sum is positive, both lags 0
        queue_compute(1'b0);
        // tie on pair x: mic one at 2, mic two at 0 and 4 -> lags -2 and +2
        // score the same and -2 must win; pair y lands at -4
        queue_capture(12'd0,    12'd4095, 12'd0,    12'd4095, 1'b0);
        queue_capture(12'd0,    12'd0,    12'd0,    12'd0,    1'b0);
        queue_capture(12'd4095, 12'd0,    12'd0,    12'd0,    1'b0);
        queue_capture(12'd0,    12'd0,    12'd0,    12'd0,    1'b0);
        queue_capture(12'd0,    12'd4095, 12'd4095, 12'd0,    1'b0);
        queue_compute(1'b0);
        // divide boundaries and alternating bit patterns
        queue_capture(12'd19,   12'd20,   12'd39,   12'd40,   1'b0);
        pend_q[pend_q.size() - 1].drain_first = 1'b1;
        queue_capture(12'hAAA,  12'h555,  12'hFFF,  12'h001,  1'b0);
        queue_capture(12'h555,  12'hAAA,  12'h800,  12'h7FF,  1'b0);
        queue_capture(12'd4094, 12'd1,    12'd21,   12'd4095, 1'b0);
        queue_capture(12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0);
        queue_capture(12'd0,    12'd0,    12'd0,    12'd0,    1'b0);
        queue_compute(1'b0);
        // back-to-back compute with nothing new captured
        queue_compute(1'b0);

        // --- random phases: bursts of captures, each closed by a compute ---
        // Phase 11 is a sampling-timer run with no idling that wraps the
        // stores and keeps going, so the overflow captures are dropped.
        for (ph = 0; ph < 24; ph++)
        begin
            if (ph == 11)
                queue_delayed_burst(DEPTH - gen_pos + int'($urandom_range(3, 30)),
                                    pick_lag(), pick_lag(), 1'b1);
            else if ($urandom_range(99) < 75)
                queue_delayed_burst(int'($urandom_range(10, 40)), pick_lag(), pick_lag(),
                                    1'b0);
            else
            begin
                n = int'($urandom_range(1, 30));
                repeat (n)
                    queue_capture(pick_raw(), pick_raw(), pick_raw(), pick_raw(), 1'b0);
            end
            queue_compute($urandom_range(99) < 30);
            if ($urandom_range(99) < 8)
                queue_compute(1'b0);
        end

        // size the watchdog from the slowest legal run, with wide margin
        n_items   = pend_q.size();
        n_compute = 0;
        foreach (pend_q[i])
            if (pend_q[i].command == CMD_COMPUTE)
                n_compute++;
        cycle_limit = 3 * (n_compute * COMPUTE_CYCLES + 5 * n_items) + 20000;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        fork
            begin
                // every transfer in and every owed lag pair back
                while (pend_q.size() != 0 || start || lag_expect_q.size() != 0)
                    @(negedge clk);
                repeat (40) @(posedge clk);
            end
            begin
                while (cycle_count < cycle_limit)
                    @(posedge clk);
                timed_out = 1'b1;
            end
        join_any
        disable fork;

        while (!timed_out && lag_expect_q.size() != 0)
        begin
            flag_mismatch("compute never returned a result");
            void'(lag_expect_q.pop_front());
        end

        $display("Run: %0d captures stored, %0d dropped while stores were full,",
                 n_stored, n_dropped);
        $display("     %0d lag pairs checked over %0d cycles, %0d mismatches.",
                 n_results, cycle_count, n_errors);
        if (timed_out)
            $display("CHECKS FAILED");
        else if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
